// ===== src/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Word and hash types, control structs, sequencer states, the initial hash
// value, the round constants, and the sigma functions of the compression and the schedule.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [0:7] hash_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FIN,
    ST_PAD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_PAD,
    AFT_OUT
  } after_e;

  typedef struct packed {
    logic       load_byte;
    logic       shift;
    logic [7:0] data;
  } sched_ctrl_t;

  typedef struct packed {
    logic init;
    logic step;
  } round_ctrl_t;

  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [63:0] BlockBits = 64'd512;

  localparam hash_t InitHash = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

// ===== src/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and returns the digest as four 64-bit words.
// ----------------------------------------------------------------------------
// The input channel takes one beat per message byte; a beat with
// end_of_message_i set closes the message after its own byte, if any.
// A beat with byte_valid_i low and end_of_message_i low does nothing.
// Most beats leave the block ready for the next one. The beat that fills a
// 64-byte block starts the compression: the shared round unit does one
// round per cycle, then the result is folded into the chaining value; the
// block is not ready until the fold is done. At the end of a message the
// padding bytes enter one per cycle via the same buffer, then one or two compressions.
// The digest leaves on the output channel as four beats, most significant
// word first, with word_index_o counting 0 to 3 and last_word_o on the last.
// A stalled receiver holds the current word; no new input is taken until the
// last word is taken, after which the block starts a fresh message.
// Reset loads the initial hash value and clears the counters; the block is
// ready as soon as reset is released.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);
  import sha256_pkg::*;

  state_e      state_q;
  state_e      state_d;
  after_e      after_q;
  after_e      after_d;
  logic [5:0]  fill_q;
  logic [5:0]  fill_d;
  logic [63:0] bits_q;
  logic [63:0] bits_d;
  logic [63:0] len_q;
  logic [63:0] len_d;
  logic [5:0]  rnd_q;
  logic [5:0]  rnd_d;
  logic [1:0]  oidx_q;
  logic [1:0]  oidx_d;
  logic        first_q;
  logic        first_d;
  logic        wrap_q;
  logic        wrap_d;
  hash_t       cv_q;
  hash_t       cv_d;

  sched_ctrl_t sched_ctrl;
  round_ctrl_t round_ctrl;
  word_t       sched_w;
  hash_t       work;
  logic        in_acc;
  logic        blk_wrap;
  logic        len_byte;

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (sched_w)
  );

  sha256_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (round_ctrl),
    .cv_i   (cv_q),
    .k_i    (round_k(rnd_q)),
    .w_i    (sched_w),
    .work_o (work)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = {cv_q[{oidx_q, 1'b0}], cv_q[{oidx_q, 1'b1}]};
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 2'd3);

  assign blk_wrap = first_q ? (fill_q >= LenStart) : wrap_q;
  assign len_byte = !first_q && !wrap_q && (fill_q >= LenStart);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (byte_valid_i && (fill_q == LastByte)) begin
            state_d = ST_COMP;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (rnd_q == LastRound) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        case (after_q)
          AFT_PAD: state_d = ST_PAD;
          AFT_OUT: state_d = ST_OUT;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_PAD: begin
        if (fill_q == LastByte) begin
          state_d = ST_COMP;
        end
      end
      ST_OUT: begin
        if (out_ready_i && (oidx_q == 2'd3)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    after_d         = after_q;
    fill_d          = fill_q;
    bits_d          = bits_q;
    len_d           = len_q;
    rnd_d           = rnd_q;
    oidx_d          = oidx_q;
    first_d         = first_q;
    wrap_d          = wrap_q;
    cv_d            = cv_q;
    sched_ctrl      = '0;
    round_ctrl.init = (state_d == ST_COMP) && (state_q != ST_COMP);
    round_ctrl.step = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (byte_valid_i) begin
            sched_ctrl.load_byte = 1'b1;
            sched_ctrl.data      = data_byte_i;
            fill_d               = fill_q + 6'd1;
            if (fill_q == LastByte) begin
              bits_d  = bits_q + BlockBits;
              after_d = end_of_message_i ? AFT_PAD : AFT_IDLE;
            end
          end
          if (end_of_message_i) begin
            len_d   = {bits_d[63:9], fill_d, 3'b000};
            first_d = 1'b1;
            wrap_d  = 1'b0;
          end
        end
      end
      ST_COMP: begin
        sched_ctrl.shift = 1'b1;
        round_ctrl.step  = 1'b1;
        rnd_d            = rnd_q + 6'd1;
      end
      ST_FIN: begin
        for (int i = 0; i < 8; i++) begin
          cv_d[i] = cv_q[i] + work[i];
        end
      end
      ST_PAD: begin
        sched_ctrl.load_byte = 1'b1;
        if (first_q) begin
          sched_ctrl.data = PadMarker;
        end else if (len_byte) begin
          sched_ctrl.data = len_q[63:56];
          len_d           = {len_q[55:0], 8'h00};
        end else begin
          sched_ctrl.data = 8'h00;
        end
        first_d = 1'b0;
        wrap_d  = blk_wrap;
        fill_d  = fill_q + 6'd1;
        if (fill_q == LastByte) begin
          after_d = blk_wrap ? AFT_PAD : AFT_OUT;
          wrap_d  = 1'b0;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            cv_d   = InitHash;
            bits_d = '0;
            fill_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      after_q <= AFT_IDLE;
      fill_q  <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      first_q <= 1'b0;
      wrap_q  <= 1'b0;
      cv_q    <= InitHash;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
      first_q <= first_d;
      wrap_q  <= wrap_d;
      cv_q    <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

endmodule

// ===== src/sha256_sched.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block buffer and message schedule
// Bytes shift into a sixteen-word window; during compression the window
// shifts one word per round and the expanded word enters at the far end.
// ----------------------------------------------------------------------------
module sha256_sched (
  input  logic                     clk_i,
  input  sha256_pkg::sched_ctrl_t  ctrl_i,
  output sha256_pkg::word_t        w_o
);
  import sha256_pkg::*;

  logic [511:0] win_q;
  logic [511:0] win_d;
  word_t        tap0;
  word_t        tap1;
  word_t        tap9;
  word_t        tap14;
  word_t        next_w;

  assign tap0  = win_q[511:480];
  assign tap1  = win_q[479:448];
  assign tap9  = win_q[223:192];
  assign tap14 = win_q[63:32];

  assign next_w = tap0 + small_sigma0(tap1) + tap9 + small_sigma1(tap14);
  assign w_o    = tap0;

  always_comb begin
    win_d = win_q;
    if (ctrl_i.load_byte) begin
      win_d = {win_q[503:0], ctrl_i.data};
    end else if (ctrl_i.shift) begin
      win_d = {win_q[479:0], next_w};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// ===== src/sha256_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds the eight working words and applies one compression round per cycle while step is set.
// ----------------------------------------------------------------------------
module sha256_round (
  input  logic                     clk_i,
  input  sha256_pkg::round_ctrl_t  ctrl_i,
  input  sha256_pkg::hash_t        cv_i,
  input  sha256_pkg::word_t        k_i,
  input  sha256_pkg::word_t        w_i,
  output sha256_pkg::hash_t        work_o
);
  import sha256_pkg::*;

  hash_t r_q;
  hash_t r_d;
  word_t choose;
  word_t major;
  word_t t1;
  word_t t2;

  assign choose = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
  assign major  = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
  assign t1     = r_q[7] + big_sigma1(r_q[4]) + choose + k_i + w_i;
  assign t2     = big_sigma0(r_q[0]) + major;

  always_comb begin
    r_d = r_q;
    if (ctrl_i.init) begin
      r_d = cv_i;
    end else if (ctrl_i.step) begin
      r_d[7] = r_q[6];
      r_d[6] = r_q[5];
      r_d[5] = r_q[4];
      r_d[4] = r_q[3] + t1;
      r_d[3] = r_q[2];
      r_d[2] = r_q[1];
      r_d[1] = r_q[0];
      r_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  assign work_o = r_q;

endmodule
